// ===== hdl/pal_pkg.sv =====
// types and constants shared by the positional array list and its cells
package pal_pkg;

	// stream field widths
	localparam int IN_W  = 40;
	localparam int OUT_W = 48;

	// operation codes
	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_SEARCH = 2'd2;

	// status codes
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_FULL    = 3'd1;
	localparam logic [2:0] ST_EMPTY   = 3'd2;
	localparam logic [2:0] ST_BAD_INS = 3'd3;
	localparam logic [2:0] ST_BAD_REM = 3'd4;

	// cell load selection
	localparam logic [1:0] SEL_HOLD  = 2'd0;
	localparam logic [1:0] SEL_NEW   = 2'd1;
	localparam logic [1:0] SEL_LEFT  = 2'd2;
	localparam logic [1:0] SEL_RIGHT = 2'd3;

	// per-cell control from the list controller
	typedef struct packed {
		logic [1:0] sel;
		logic       cmp;
	} cell_ctl_t;

endpackage

// ===== hdl/pal_cell.sv =====
// one storage cell of the list: holds an entry, shifts with its neighbors, compares a key
module pal_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  pal_pkg::cell_ctl_t ctl,
	input  logic [31:0]        new_value,
	input  logic [31:0]        left_value,
	input  logic [31:0]        right_value,
	input  logic [31:0]        key,
	output logic [31:0]        data_q,
	output logic               match_q
);
	import pal_pkg::*;

	// entry register, loads from the new value or a neighbor
	always_ff @(posedge clk) begin
		if (en) begin
			case (ctl.sel)
				SEL_NEW:   data_q <= new_value;
				SEL_LEFT:  data_q <= left_value;
				SEL_RIGHT: data_q <= right_value;
				default:   data_q <= data_q;
			endcase
		end
	end

	// match flag, set only by a search over a live entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (en) begin
			match_q <= ctl.cmp && (data_q == key);
		end
	end

endmodule

// ===== hdl/positional_array_list.sv =====
// top level of the positional array list: list controller, cell chain and result register
//
//  channel  | dir | bits | contents
//  ---------+-----+------+-------------------------------------------------
//  s_t*     | in  |  40  | mode[1:0] value[33:2] position[38:34]
//  m_t*     | out |  48  | status[2:0] removed_value[34:3] found[35]
//           |     |      | found_index[39:36] count[44:40] is_empty[45]
//           |     |      | is_full[46]
//
// for each item the cells shift or compare in the accept cycle; the first match is then
// encoded and loaded into the output register once that register can take the result.
// a new item is taken once the previous result has moved into the output register,
// so a stalled m_tready holds at most one finished result plus one in flight.
// reset clears the entry count, the match flags and both valid flags; entries keep
// whatever they held and are only read below the count.
module positional_array_list #(
	parameter int CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [pal_pkg::IN_W-1:0]   s_tdata,   // mode, value, position
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [pal_pkg::OUT_W-1:0]  m_tdata    // status, removed_value, found,
	                                               // found_index, count, is_empty, is_full
);
	import pal_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = $clog2(CAPACITY);
	localparam int PW = (CW > 5) ? CW : 5;

	logic [CW-1:0]       count_q;
	logic                pend_q;
	logic [2:0]          status_s1;
	logic [31:0]         removed_s1;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                accept;
	logic                done;
	logic [1:0]          mode;
	logic [31:0]         value;
	logic [4:0]          position;
	logic [PW-1:0]       pos_w;
	logic [PW-1:0]       cnt_w;
	logic                ins_ok;
	logic                rem_ok;
	logic                srch;
	logic [2:0]          status_d;
	logic [31:0]         removed_d;

	logic [31:0]         cell_data [CAPACITY];
	logic [CAPACITY-1:0] cell_match;
	cell_ctl_t           cell_ctl [CAPACITY];

	logic                found;
	logic [IW-1:0]       found_idx;

	// item fields
	assign mode     = s_tdata[1:0];
	assign value    = s_tdata[33:2];
	assign position = s_tdata[38:34];
	assign pos_w    = PW'(position);
	assign cnt_w    = PW'(count_q);

	assign s_tready = !pend_q;
	assign accept   = s_tvalid && s_tready;
	assign done     = pend_q && (!m_tvalid_q || m_tready);

	// operation checks and status
	always_comb begin
		ins_ok   = 1'b0;
		rem_ok   = 1'b0;
		srch     = 1'b0;
		status_d = ST_OK;
		case (mode)
			MODE_INSERT: begin
				if (count_q == CW'(CAPACITY)) begin
					status_d = ST_FULL;
				end else if (pos_w > cnt_w) begin
					status_d = ST_BAD_INS;
				end else begin
					ins_ok = 1'b1;
				end
			end
			MODE_REMOVE: begin
				if (count_q == '0) begin
					status_d = ST_EMPTY;
				end else if (pos_w >= cnt_w) begin
					status_d = ST_BAD_REM;
				end else begin
					rem_ok = 1'b1;
				end
			end
			MODE_SEARCH: srch = 1'b1;
			default: status_d = ST_OK;
		endcase
	end

	// value leaving the list on a remove
	assign removed_d = rem_ok ? cell_data[pos_w[IW-1:0]] : '0;

	// cell chain
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [31:0] left_v;
		logic [31:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_left
			assign left_v = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_right
			assign right_v = cell_data[i+1];
		end

		// per-cell control from its place against position and count
		always_comb begin
			cell_ctl[i].sel = SEL_HOLD;
			if (ins_ok && PW'(i) == pos_w) begin
				cell_ctl[i].sel = SEL_NEW;
			end else if (ins_ok && PW'(i) > pos_w) begin
				cell_ctl[i].sel = SEL_LEFT;
			end else if (rem_ok && PW'(i) >= pos_w) begin
				cell_ctl[i].sel = SEL_RIGHT;
			end
			cell_ctl[i].cmp = srch && (PW'(i) < cnt_w);
		end

		pal_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.en          (accept),
			.ctl         (cell_ctl[i]),
			.new_value   (value),
			.left_value  (left_v),
			.right_value (right_v),
			.key         (value),
			.data_q      (cell_data[i]),
			.match_q     (cell_match[i])
		);
	end

	// count and pending result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_q  <= 1'b0;
		end else begin
			if (accept) begin
				if (ins_ok) begin
					count_q <= count_q + CW'(1);
				end else if (rem_ok) begin
					count_q <= count_q - CW'(1);
				end
			end
			if (accept) begin
				pend_q <= 1'b1;
			end else if (done) begin
				pend_q <= 1'b0;
			end
		end
	end

	// first stage result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1  <= status_d;
			removed_s1 <= removed_d;
		end
	end

	// first matching position
	always_comb begin
		found     = |cell_match;
		found_idx = '0;
		for (int k = CAPACITY - 1; k >= 0; k--) begin
			if (cell_match[k]) begin
				found_idx = IW'(k);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			m_tdata_q <= {1'b0,
				(count_q == CW'(CAPACITY)),
				(count_q == '0),
				5'(count_q),
				4'(found_idx),
				found,
				removed_s1,
				status_s1};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
